### src/lphs_pkg.sv
// Shared types and constants for the linear probing hash set.
// Holds the transaction structs, operation and status codes, table sizing
// and the controller state type. No dependencies.
`default_nettype none

package lphs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 32;

  localparam int SLOT_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = KEY_WIDTH + 1;

  // Fixed field widths of the transactions.
  localparam int OP_W          = 2;
  localparam int IN_KEY_W      = 32;
  localparam int HASH_W        = 32;
  localparam int STATUS_W      = 2;
  localparam int SLOT_INDEX_W  = 10;
  localparam int ENTRY_COUNT_W = 11;
  localparam int SLOT_LIMIT_W  = 11;

  // Start slot divider: dividend bits retired per cycle.
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = HASH_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int REM_W      = SLOT_W + 1;

  // Configuration port.
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;
  localparam int SLOT_LIMIT_RESET = 769;

  localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [IN_KEY_W-1:0] key;
    logic [HASH_W-1:0]   key_hash;
  } in_t;

  typedef struct packed {
    logic                     found;
    logic [STATUS_W-1:0]      status;
    logic [SLOT_INDEX_W-1:0]  slot_index;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_REPLY
  } state_t;

endpackage

`default_nettype wire

### src/lphs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module lphs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/lphs_mod.sv
// Iterative remainder unit: key_hash modulo the table size, DIV_BITS
// quotient bits per cycle. Depends on lphs_pkg.
`default_nettype none

module lphs_mod
  import lphs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [HASH_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]  divisor,
  output      logic              done,
  output      logic [SLOT_W-1:0] rem
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] step;
  logic [HASH_W-1:0]    shreg;
  logic [CNT_W-1:0]     dvs;
  logic [SLOT_W-1:0]    rem_next;

  // Restoring division: the partial remainder stays below the divisor,
  // so a single compare and subtract per bit keeps it in range.
  always_comb begin
    logic [REM_W-1:0] r;
    r = REM_W'(rem);
    for (int j = 0; j < DIV_BITS; j++) begin
      r = {r[REM_W-2:0], shreg[HASH_W-1-j]};
      if (r >= REM_W'(dvs)) begin
        r = r - REM_W'(dvs);
      end
    end
    rem_next = r[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + DIV_CNT_W'(1);
        if (step == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << DIV_BITS;
      rem   <= rem_next;
    end
  end

endmodule

`default_nettype wire

### src/lphs_probe.sv
// Probe controller: clears the slot memory after reset, runs the start
// slot division, walks the slots one per cycle and holds the result.
// Depends on lphs_pkg, lphs_ram and lphs_mod.
`default_nettype none

module lphs_probe
  import lphs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CNT_W-1:0] size,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire in_t              in_data,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      out_t             out_data
);

  state_t                 state, state_next;
  logic [SLOT_W-1:0]      clr_addr;
  logic [OP_W-1:0]        op;
  logic [KEY_WIDTH-1:0]   key;
  logic [CNT_W-1:0]       size_r;
  logic [SLOT_W-1:0]      slot, slot_next;
  logic [SLOT_W-1:0]      lap;
  logic [CNT_W-1:0]       count, count_next;
  out_t                   res, res_next;

  logic                   we;
  logic [SLOT_W-1:0]      waddr;
  logic [ENTRY_W-1:0]     wdata;
  logic [SLOT_W-1:0]      raddr;
  logic [ENTRY_W-1:0]     rdata;

  logic                   mod_start;
  logic                   mod_done;
  logic [SLOT_W-1:0]      mod_rem;

  logic                   used;
  logic                   hit;
  logic                   last_lap;
  logic [SLOT_W-1:0]      slot_wrap;
  logic                   out_load;
  logic                   lap_clear;
  logic                   lap_inc;

  lphs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  lphs_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (in_data.key_hash),
    .divisor  (size),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign in_stall  = (state != S_IDLE);
  assign used      = rdata[KEY_WIDTH];
  assign hit       = (op == OP_INSERT) ? !used : (used && (rdata[KEY_WIDTH-1:0] == key));
  assign last_lap  = (lap == SLOT_W'(size_r - CNT_W'(1)));
  assign slot_wrap = ((CNT_W'(slot) + CNT_W'(1)) == size_r) ? '0 : slot + SLOT_W'(1);
  assign out_load  = (state == S_REPLY) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    slot_next  = slot;
    count_next = count;
    res_next   = res;
    we         = 1'b0;
    waddr      = slot;
    wdata      = {1'b0, key};
    raddr      = slot;
    mod_start  = 1'b0;
    lap_clear  = 1'b0;
    lap_inc    = 1'b0;

    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
        if (clr_addr == SLOT_W'(TABLE_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mod_start  = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        raddr = mod_rem;
        if (mod_done) begin
          slot_next = mod_rem;
          lap_clear = 1'b1;
          if (op == OP_SEARCH || op == OP_INSERT || op == OP_REMOVE) begin
            state_next = S_PROBE;
          end else begin
            res_next   = '{found: 1'b0, status: STAT_DONE, slot_index: '0,
                           entry_count: ENTRY_COUNT_W'(count)};
            state_next = S_REPLY;
          end
        end
      end
      S_PROBE: begin
        if (hit) begin
          state_next = S_REPLY;
          if (op == OP_INSERT) begin
            we         = 1'b1;
            wdata      = {1'b1, key};
            count_next = count + CNT_W'(1);
          end else if (op == OP_REMOVE) begin
            we = 1'b1;
            if (count != '0) begin
              count_next = count - CNT_W'(1);
            end
          end
          res_next = '{found: (op != OP_INSERT), status: STAT_DONE,
                       slot_index: SLOT_INDEX_W'(slot),
                       entry_count: ENTRY_COUNT_W'(count_next)};
        end else if (last_lap) begin
          state_next = S_REPLY;
          res_next   = '{found: 1'b0,
                         status: (op == OP_INSERT) ? STAT_FULL : STAT_NOT_FOUND,
                         slot_index: '0, entry_count: ENTRY_COUNT_W'(count)};
        end else begin
          // Issue the next slot's read now so one slot is checked per cycle.
          slot_next = slot_wrap;
          raddr     = slot_wrap;
          lap_inc   = 1'b1;
        end
      end
      S_REPLY: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + SLOT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op     <= in_data.op;
      key    <= in_data.key[KEY_WIDTH-1:0];
      size_r <= size;
    end
    if (lap_clear) begin
      lap <= '0;
    end else if (lap_inc) begin
      lap <= lap + SLOT_W'(1);
    end
    slot <= slot_next;
    res  <= res_next;
    if (out_load) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

### src/linear_probe_hash_set.sv
// Linear probing hash set. A transaction on the input channel carries an
// operation (search, insert, remove), a key and its precomputed hash. Each
// transaction yields exactly one result transaction with found, status,
// slot_index and the number of used slots after the operation.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. The table size register sits at byte address 0 of the APB
// port; the user is to write it only while the block is idle, which the
// block itself does not enforce. Each transaction is accepted, its start
// slot is found (hash modulo table size, 4 bits per cycle), the first slot
// is read, the slots are probed one per cycle, up to the table size, and
// the result is loaded into the output register. The slot memory, with
// its single read port walked one slot per cycle, sets the probe rate. One
// transaction is in flight at a time; the next one is accepted while the
// previous result still waits in the output register.
// After reset the block clears the used marks of all 1024 slots, one per
// cycle, and stalls its input until the clear is done. A stalled result holds.
// Depends on lphs_pkg and lphs_probe.
`default_nettype none

module linear_probe_hash_set
  import lphs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire in_t                in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      out_t               out_data
);

  logic [SLOT_LIMIT_W-1:0] slot_limit;
  logic [CNT_W-1:0]        size_eff;
  logic                    sel_size;

  assign pready   = 1'b1;
  assign sel_size = (paddr[PADDR_W-1] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= SLOT_LIMIT_W'(SLOT_LIMIT_RESET);
    end else if (psel && penable && pwrite && sel_size) begin
      slot_limit <= pwdata[SLOT_LIMIT_W-1:0];
    end
  end

  assign prdata = sel_size ? PDATA_W'(slot_limit) : '0;

  // Out of range sizes fold into 1..TABLE_DEPTH.
  always_comb begin
    if (slot_limit == '0) begin
      size_eff = CNT_W'(1);
    end else if (32'(slot_limit) > 32'(TABLE_DEPTH)) begin
      size_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      size_eff = CNT_W'(slot_limit);
    end
  end

  lphs_probe u_probe (
    .clk       (clk),
    .rst       (rst),
    .size      (size_eff),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### src/lphs_checker.sv
// Port-level checks for linear_probe_hash_set, bound to the top level.
// Depends on lphs_pkg.
`default_nettype none

module lphs_checker
  import lphs_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_data
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && in_stall)
    else $error("output valid or input open right after reset");

  // One transaction at a time: the input closes right after an accept.
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input still open after an accepted transaction");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> out_data.status == STAT_DONE)
    else $error("found result with a failure status");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STAT_DONE |-> out_data.slot_index == '0
      && !out_data.found)
    else $error("failed operation reports a slot");

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
